// ===== sv/tcb_pkg.sv =====
package tcb_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 14;
   localparam int WEIGHT_BITS          = 16;
   localparam int QUOT_BITS            = WEIGHT_BITS + 1;
   localparam int CSR_INDEX_BITS       = 3;
   localparam int MID_DEPTH            = 8;
   localparam int OUT_DEPTH            = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_A_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_X = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_Y = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_C_X = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_C_Y = 3'd5;

   function automatic int mag_bits(input int coord_bits);
      return 2 * coord_bits + 2;
   endfunction

   function automatic int mid_bits(input int coord_bits);
      return 5 + 4 * mag_bits(coord_bits);
   endfunction

endpackage

// ===== sv/tcb_fifo.sv =====
module tcb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (AW+1)'(DEPTH));

endmodule

// ===== sv/tcb_front.sv =====
module tcb_front #(
   parameter int COORD_BITS = tcb_pkg::COORD_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic signed [COORD_BITS-1:0]               point_x,
   input  logic signed [COORD_BITS-1:0]               point_y,
   input  logic signed [COORD_BITS-1:0]               vert [6],
   output logic                                       out_valid,
   output logic [tcb_pkg::mid_bits(COORD_BITS)-1:0]   out_data
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int EW = PW + 1;
   localparam int MW = tcb_pkg::mag_bits(COORD_BITS);

   logic signed [DW-1:0] d_ff [16];
   logic signed [DW-1:0] d_in [16];
   logic signed [PW-1:0] p_ff [8];
   logic signed [EW-1:0] e_ff [4];
   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [COORD_BITS-1:0] ux [4];
   logic signed [COORD_BITS-1:0] uy [4];
   logic signed [COORD_BITS-1:0] vx [4];
   logic signed [COORD_BITS-1:0] vy [4];
   logic signed [COORD_BITS-1:0] qx [4];
   logic signed [COORD_BITS-1:0] qy [4];
   logic [MW-1:0]        mag [4];
   logic [2:0]           neg;
   logic                 all_pos, all_neg;

   always_comb begin
      ux[0] = vert[0]; uy[0] = vert[1]; vx[0] = vert[2]; vy[0] = vert[3];
      ux[1] = vert[2]; uy[1] = vert[3]; vx[1] = vert[4]; vy[1] = vert[5];
      ux[2] = vert[4]; uy[2] = vert[5]; vx[2] = vert[0]; vy[2] = vert[1];
      ux[3] = vert[2]; uy[3] = vert[3]; vx[3] = vert[4]; vy[3] = vert[5];
      for (int k = 0; k < 3; k++) begin
         qx[k] = point_x;
         qy[k] = point_y;
      end
      qx[3] = vert[0];
      qy[3] = vert[1];
      for (int k = 0; k < 4; k++) begin
         d_in[4*k]   = DW'(ux[k]) - DW'(vx[k]);
         d_in[4*k+1] = DW'(uy[k]) - DW'(qy[k]);
         d_in[4*k+2] = DW'(uy[k]) - DW'(vy[k]);
         d_in[4*k+3] = DW'(ux[k]) - DW'(qx[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      for (int k = 0; k < 8; k++) begin
         p_ff[k] <= PW'(d_ff[2*k]) * PW'(d_ff[2*k+1]);
      end
      for (int k = 0; k < 4; k++) begin
         e_ff[k] <= EW'(p_ff[2*k]) - EW'(p_ff[2*k+1]);
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mag[k] = e_ff[k][EW-1] ? MW'(-e_ff[k]) : MW'(e_ff[k]);
      end
      neg[0] = e_ff[1][EW-1] ^ e_ff[3][EW-1];
      neg[1] = e_ff[2][EW-1] ^ e_ff[3][EW-1];
      neg[2] = e_ff[0][EW-1] ^ e_ff[3][EW-1];
      all_pos = 1'b1;
      all_neg = 1'b1;
      for (int k = 0; k < 3; k++) begin
         all_pos = all_pos & !e_ff[k][EW-1] & (e_ff[k] != '0);
         all_neg = all_neg & e_ff[k][EW-1];
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = {all_pos | all_neg, (e_ff[3] == '0), neg, mag[3], mag[0], mag[2], mag[1]};

endmodule

// ===== sv/tcb_back.sv =====
module tcb_back #(
   parameter int COORD_BITS       = tcb_pkg::COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = tcb_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [tcb_pkg::mid_bits(COORD_BITS)-1:0] in_data,
   output logic                                     in_pop,
   input  logic                                     out_ready,
   output logic                                     out_valid,
   output logic [2+3*tcb_pkg::WEIGHT_BITS-1:0]      out_data
);

   localparam int MW = tcb_pkg::mag_bits(COORD_BITS);
   localparam int QB = tcb_pkg::QUOT_BITS;
   localparam int WB = tcb_pkg::WEIGHT_BITS;
   localparam int RW = MW + WEIGHT_FRAC_BITS + QB;
   localparam int NS = QB + 1;

   logic            vld_ff [NS];
   logic            cov_ff [NS];
   logic            deg_ff [NS];
   logic [MW-1:0]   den_ff [NS];
   logic [2:0]      neg_ff [NS];
   logic [2:0]      sat_ff [NS];
   logic [RW-1:0]   rem_ff [NS][3];
   logic [QB-1:0]   q_ff   [NS][3];
   logic [RW-1:0]   rem_in [NS][3];
   logic [QB-1:0]   q_in   [NS][3];
   logic [2:0]      sat0_in;
   logic            advance;
   logic [MW-1:0]   in_mag [3];
   logic [MW-1:0]   in_den;
   logic [2:0]      in_neg;
   logic [RW-1:0]   dsh;
   logic [QB-1:0]   lim, qc;
   logic [WB-1:0]   w [3];

   assign advance = out_ready;
   assign in_pop  = advance & in_valid;

   always_comb begin
      in_mag[0] = in_data[MW-1:0];
      in_mag[1] = in_data[2*MW-1:MW];
      in_mag[2] = in_data[3*MW-1:2*MW];
      in_den    = in_data[4*MW-1:3*MW];
      in_neg    = in_data[4*MW+2:4*MW];
      dsh       = '0;
      for (int l = 0; l < 3; l++) begin
         rem_in[0][l] = RW'(in_mag[l]) << WEIGHT_FRAC_BITS;
         q_in[0][l]   = '0;
         sat0_in[l]   = rem_in[0][l] >= (RW'(in_den) << QB);
      end
      for (int s = 1; s < NS; s++) begin
         for (int l = 0; l < 3; l++) begin
            dsh          = RW'(den_ff[s-1]) << (QB - s);
            rem_in[s][l] = rem_ff[s-1][l];
            q_in[s][l]   = q_ff[s-1][l];
            if (rem_ff[s-1][l] >= dsh) begin
               rem_in[s][l]       = rem_ff[s-1][l] - dsh;
               q_in[s][l][QB - s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cov_ff[0] <= in_data[4*MW+4];
         deg_ff[0] <= in_data[4*MW+3];
         den_ff[0] <= in_den;
         neg_ff[0] <= in_neg;
         sat_ff[0] <= sat0_in;
         for (int s = 1; s < NS; s++) begin
            cov_ff[s] <= cov_ff[s-1];
            deg_ff[s] <= deg_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
         end
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   always_comb begin
      lim = '0;
      qc  = '0;
      for (int l = 0; l < 3; l++) begin
         lim = neg_ff[QB][l] ? (QB'(1) << (WB - 1)) : ((QB'(1) << (WB - 1)) - QB'(1));
         qc  = (sat_ff[QB][l] || (q_ff[QB][l] > lim)) ? lim : q_ff[QB][l];
         w[l] = neg_ff[QB][l] ? WB'(-qc) : WB'(qc);
         if (deg_ff[QB]) begin
            w[l] = '0;
         end
      end
   end

   assign out_valid = advance & vld_ff[QB];
   assign out_data  = {cov_ff[QB], w[0], w[1], w[2], deg_ff[QB]};

endmodule

// ===== sv/triangle_coverage_barycentric.sv =====
// Edge-function rasteriser cell: load the three vertices through the csr port
// (only while the block is idle), then push one sample point per word. Each point
// gives one result word with strict coverage, three Q2.14 barycentric weights
// (saturated) and a degenerate flag for zero area. The block sustains one word
// per clock while results are popped; points cross the edge-function pipeline
// (difference, product, edge registers), a handoff queue of 8 words, an 18-stage
// restoring divider (stage 0 checks saturation, each later stage retires one
// quotient bit for all three weights at once) and a 4-word result queue. full
// rises once 8 words sit between port and divider, only while results are not popped.
module triangle_coverage_barycentric #(
   parameter int COORD_BITS       = tcb_pkg::COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = tcb_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [COORD_BITS-1:0]         req_point_x,
   input  logic signed [COORD_BITS-1:0]         req_point_y,
   output logic                                 empty,
   input  logic                                 pop,
   output logic                                 rsp_covered,
   output logic signed [tcb_pkg::WEIGHT_BITS-1:0] rsp_weight_a,
   output logic signed [tcb_pkg::WEIGHT_BITS-1:0] rsp_weight_b,
   output logic signed [tcb_pkg::WEIGHT_BITS-1:0] rsp_weight_c,
   output logic                                 rsp_degenerate,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                csr_data
);

   localparam int MIDW = tcb_pkg::mid_bits(COORD_BITS);
   localparam int WB   = tcb_pkg::WEIGHT_BITS;
   localparam int OW   = 2 + 3 * WB;
   localparam int CW   = $clog2(tcb_pkg::MID_DEPTH) + 1;

   logic signed [COORD_BITS-1:0] vert_ff [6];
   logic [CW-1:0]   credit_ff, credit_in;
   logic            accept;
   logic            front_valid;
   logic [MIDW-1:0] front_data;
   logic [MIDW-1:0] mid_data;
   logic            mid_empty, mid_full, mid_pop;
   logic            back_valid, out_full;
   logic [OW-1:0]   back_data, rsp_data;

   assign csr_ready = 1'b1;
   assign accept    = push & !full;
   assign full      = (credit_ff == CW'(tcb_pkg::MID_DEPTH));
   assign credit_in = credit_ff + CW'(accept) - CW'(mid_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         for (int r = 0; r < 6; r++) begin
            vert_ff[r] <= '0;
         end
      end else begin
         credit_ff <= credit_in;
         if (csr_valid) begin
            case (csr_index)
               tcb_pkg::REG_A_X: vert_ff[0] <= csr_data;
               tcb_pkg::REG_A_Y: vert_ff[1] <= csr_data;
               tcb_pkg::REG_B_X: vert_ff[2] <= csr_data;
               tcb_pkg::REG_B_Y: vert_ff[3] <= csr_data;
               tcb_pkg::REG_C_X: vert_ff[4] <= csr_data;
               tcb_pkg::REG_C_Y: vert_ff[5] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   tcb_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .vert      (vert_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   tcb_fifo #(.WIDTH(MIDW), .DEPTH(tcb_pkg::MID_DEPTH)) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_data),
      .rd_en   (mid_pop),
      .rd_data (mid_data),
      .empty   (mid_empty),
      .full    (mid_full)
   );

   tcb_back #(.COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_data   (mid_data),
      .in_pop    (mid_pop),
      .out_ready (!out_full),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   tcb_fifo #(.WIDTH(OW), .DEPTH(tcb_pkg::OUT_DEPTH)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_valid),
      .wr_data (back_data),
      .rd_en   (pop & !empty),
      .rd_data (rsp_data),
      .empty   (empty),
      .full    (out_full)
   );

   assign rsp_covered    = rsp_data[OW-1] & !mid_full | rsp_data[OW-1] & mid_full;
   assign rsp_weight_a   = rsp_data[OW-2 -: WB];
   assign rsp_weight_b   = rsp_data[OW-2-WB -: WB];
   assign rsp_weight_c   = rsp_data[OW-2-2*WB -: WB];
   assign rsp_degenerate = rsp_data[0];

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

class raster_scoreboard;
   typedef struct packed {
      logic              covered;
      logic signed [15:0] wa;
      logic signed [15:0] wb;
      logic signed [15:0] wc;
      logic              degenerate;
   } sample_type;

   logic signed [15:0] vx[6];
   sample_type         pending[$];
   int                 errors;
   int                 checked;
   int                 covered_seen;
   int                 degen_seen;
   int                 sat_seen;

   function new();
      foreach (vx[i]) vx[i] = '0;
      errors = 0;
      checked = 0;
      covered_seen = 0;
      degen_seen = 0;
      sat_seen = 0;
   endfunction

   function void set_vertex(int idx, logic [15:0] v);
      if (idx < 6) vx[idx] = v;
   endfunction

   function logic signed [39:0] edge_fn(longint ux, longint uy, longint wx, longint wy,
                                        longint px, longint py);
      return (ux - wx) * (uy - py) - (uy - wy) * (ux - px);
   endfunction

   function logic [15:0] ratio(logic signed [39:0] e, logic signed [39:0] area);
      logic        n;
      logic [79:0] num;
      logic [79:0] den;
      logic [79:0] q;
      logic [79:0] lim;
      n = (e < 0) != (area < 0);
      num = (e < 0) ? -e : e;
      den = (area < 0) ? -area : area;
      q = (num << 14) / den;
      lim = n ? 80'd32768 : 80'd32767;
      if (q > lim) q = lim;
      if (n) q = 80'd65536 - q;
      return q[15:0];
   endfunction

   function void note_point(logic signed [15:0] px, logic signed [15:0] py);
      sample_type         s;
      logic signed [39:0] eab, ebc, eca, area;
      eab = edge_fn(vx[0], vx[1], vx[2], vx[3], px, py);
      ebc = edge_fn(vx[2], vx[3], vx[4], vx[5], px, py);
      eca = edge_fn(vx[4], vx[5], vx[0], vx[1], px, py);
      area = edge_fn(vx[2], vx[3], vx[4], vx[5], vx[0], vx[1]);
      s.covered = (eab > 0 && ebc > 0 && eca > 0) || (eab < 0 && ebc < 0 && eca < 0);
      if (area == 0) begin
         s.wa = 0;
         s.wb = 0;
         s.wc = 0;
         s.degenerate = 1'b1;
      end else begin
         s.wa = ratio(ebc, area);
         s.wb = ratio(eca, area);
         s.wc = ratio(eab, area);
         s.degenerate = 1'b0;
      end
      pending.push_back(s);
   endfunction

   function void check_word(sample_type got);
      sample_type x;
      if (pending.size() == 0) begin
         $error("unexpected result word");
         errors++;
         return;
      end
      x = pending.pop_front();
      checked++;
      if (got.covered) covered_seen++;
      if (got.degenerate) degen_seen++;
      if (got.wa == 16'sh7fff || got.wa == -16'sh8000) sat_seen++;
      if (got.covered !== x.covered) begin
         $error("covered exp %0d got %0d", x.covered, got.covered);
         errors++;
      end
      if (got.wa !== x.wa) begin
         $error("weight_a exp %0d got %0d", x.wa, got.wa);
         errors++;
      end
      if (got.wb !== x.wb) begin
         $error("weight_b exp %0d got %0d", x.wb, got.wb);
         errors++;
      end
      if (got.wc !== x.wc) begin
         $error("weight_c exp %0d got %0d", x.wc, got.wc);
         errors++;
      end
      if (got.degenerate !== x.degenerate) begin
         $error("degenerate exp %0d got %0d", x.degenerate, got.degenerate);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam int WATCHDOG_LIMIT = 5000;

   logic                        clock;
   logic                        reset;
   logic                        push;
   logic                        full;
   logic signed [15:0]          req_point_x;
   logic signed [15:0]          req_point_y;
   logic                        empty;
   logic                        pop;
   logic                        rsp_covered;
   logic signed [15:0]          rsp_weight_a;
   logic signed [15:0]          rsp_weight_b;
   logic signed [15:0]          rsp_weight_c;
   logic                        rsp_degenerate;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [tcb_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [15:0]                 csr_data;

   raster_scoreboard sb;
   int               send_idle;
   int               recv_stall;
   int               stall_cycles;
   int               points_sent;
   int               triangles;

   triangle_coverage_barycentric u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .empty(empty), .pop(pop), .rsp_covered(rsp_covered),
      .rsp_weight_a(rsp_weight_a), .rsp_weight_b(rsp_weight_b),
      .rsp_weight_c(rsp_weight_c), .rsp_degenerate(rsp_degenerate),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_point_x = '0;
      req_point_y = '0;
      send_idle = 0;
      recv_stall = 0;
      stall_cycles = 0;
      points_sent = 0;
      triangles = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            sb.check_word({rsp_covered, rsp_weight_a, rsp_weight_b, rsp_weight_c,
                           rsp_degenerate});
         pop <= ($urandom_range(99) >= recv_stall);
         if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [tcb_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_vertex(idx, v);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic load_triangle(input logic [15:0] v[6]);
      drain();
      write_reg(tcb_pkg::REG_A_X, v[0]);
      write_reg(tcb_pkg::REG_A_Y, v[1]);
      write_reg(tcb_pkg::REG_B_X, v[2]);
      write_reg(tcb_pkg::REG_B_Y, v[3]);
      write_reg(tcb_pkg::REG_C_X, v[4]);
      write_reg(tcb_pkg::REG_C_Y, v[5]);
      write_reg(3'd6, 16'($urandom));
      write_reg(3'd7, 16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
      triangles++;
   endtask

   task automatic send_point(input logic [15:0] px, input logic [15:0] py);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_point(px, py);
      points_sent++;
   endtask

   function automatic logic [15:0] pick_coord(int span);
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   task automatic random_triangle();
      logic [15:0] v[6];
      int          span;
      span = ($urandom_range(3) == 0) ? 32767 : 2000;
      foreach (v[i]) v[i] = pick_coord(span);
      if ($urandom_range(9) == 0) begin
         v[4] = v[2] + (v[2] - v[0]);
         v[5] = v[3] + (v[3] - v[1]);
      end
      load_triangle(v);
   endtask

   initial begin
      logic [15:0] tri_v[6];
      logic [15:0] lo_x, hi_x, lo_y, hi_y;
      int          phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_point(16'h0000, 16'h0000);
      tri_v = '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100};
      load_triangle(tri_v);
      send_point(16'h0040, 16'h0040);
      send_point(16'h0080, 16'h0000);
      send_point(16'h0000, 16'h0000);
      send_point(16'h0100, 16'h0000);
      send_point(16'h8000, 16'h8000);
      send_point(16'h7fff, 16'h7fff);
      send_point(16'h8000, 16'h7fff);
      send_point(16'h7fff, 16'h8000);
      send_point(16'hffff, 16'h0001);
      tri_v = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000};
      load_triangle(tri_v);
      send_point(16'h0040, 16'h0040);
      send_point(16'h0200, 16'h0200);
      tri_v = '{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
      load_triangle(tri_v);
      send_point(16'h0000, 16'h0000);
      send_point(16'h7fff, 16'h7fff);
      send_point(16'h8000, 16'h8000);
      tri_v = '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001};
      load_triangle(tri_v);
      send_point(16'h7fff, 16'h7fff);
      send_point(16'h8000, 16'h0000);
      tri_v = '{16'h0010, 16'h0010, 16'h0020, 16'h0020, 16'h0030, 16'h0030};
      load_triangle(tri_v);
      send_point(16'h0015, 16'h0000);
      send_point(16'h8000, 16'h7fff);

      for (int n = 0; n < 1250; n++) begin
         if (n % 50 == 0) begin
            phase = (n / 50) % 4;
            send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 20 : 70) : 0;
            recv_stall = (phase == 2) ? 70 : (phase == 3) ? 20 : 0;
            random_triangle();
            lo_x = sb.vx[0];
            hi_x = sb.vx[2];
            lo_y = sb.vx[1];
            hi_y = sb.vx[5];
         end
         if ($urandom_range(9) < 7)
            send_point(16'($signed(lo_x) + ($signed(hi_x) - $signed(lo_x)) *
                           $signed(17'($urandom_range(100))) / 100),
                       16'($signed(lo_y) + ($signed(hi_y) - $signed(lo_y)) *
                           $signed(17'($urandom_range(100))) / 100));
         else
            send_point(pick_coord(32767), pick_coord(32767));
      end
      recv_stall = 0;
      drain();
      $display("covered %0d points over %0d triangles: %0d results, %0d covered,",
               points_sent, triangles, sb.checked, sb.covered_seen);
      $display("  %0d degenerate, %0d saturated weight_a", sb.degen_seen, sb.sat_seen);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule
